// ===== src/eisenstein_integer_alu_defines.svh =====
// Assertion macros used by the Eisenstein integer ALU top level.
`ifndef EISENSTEIN_INTEGER_ALU_DEFINES_SVH
`define EISENSTEIN_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EIA_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EIA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/eia_pkg.sv =====
// Types, constants and the micro-operation table of the Eisenstein integer ALU.
`default_nettype none
package eia_pkg;

  localparam int COMP_W    = 32;
  localparam int NORM_W    = 64;
  localparam int EXP_W     = 6;
  localparam int ACC_W     = 66;
  localparam int DEN_W     = 64;
  localparam int IDX_W     = 3;
  localparam int DIV_CNT_W = 7;

  typedef enum logic [2:0] {
    REQ_ADD, REQ_SUB, REQ_NEG, REQ_MUL, REQ_CONJ, REQ_NORM, REQ_POW, REQ_DIV
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK, ST_DIV_ZERO, ST_OVERFLOW
  } status_t;

  typedef struct packed {
    req_type_t                req_type;
    logic signed [COMP_W-1:0] x_real;
    logic signed [COMP_W-1:0] x_omega;
    logic signed [COMP_W-1:0] y_real;
    logic signed [COMP_W-1:0] y_omega;
    logic [EXP_W-1:0]         exponent;
  } in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] res_real;
    logic signed [COMP_W-1:0] res_omega;
    logic signed [COMP_W-1:0] rem_real;
    logic signed [COMP_W-1:0] rem_omega;
    logic [NORM_W-1:0]        norm_value;
    status_t                  status;
  } out_t;

  // Multiplier operand sources.
  typedef enum logic [2:0] {
    OPD_ONE, OPD_A, OPD_B, OPD_C, OPD_D, OPD_P0, OPD_P1
  } opnd_t;

  typedef enum logic [1:0] {
    ACC_LOAD, ACC_LOADNEG, ACC_ADD, ACC_SUB
  } acc_op_t;

  // Where the accumulator is written once an accumulation is complete.
  typedef enum logic [2:0] {
    DST_NONE, DST_NX, DST_NY, DST_R0, DST_R1, DST_R2, DST_R3
  } dst_t;

  // Micro-op sequences.
  typedef enum logic [3:0] {
    G_NORM, G_ADD, G_SUB, G_NEG, G_MUL, G_CONJ, G_PWR, G_NY, G_PA, G_PB, G_REM
  } grp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_DRAIN, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_SIGN, DV_ROUND
  } div_state_t;

  typedef struct packed {
    opnd_t   sel_a;
    opnd_t   sel_b;
    acc_op_t acc;
    dst_t    dst;
    logic    last;
  } uop_t;

  // Control that travels with a product through the multiply-accumulate pipe.
  typedef struct packed {
    logic    valid;
    acc_op_t acc;
    dst_t    dst;
  } mac_ctl_t;

  function automatic uop_t mk(opnd_t a, opnd_t b, acc_op_t op, dst_t d, logic l);
    uop_t u;
    u.sel_a = a;
    u.sel_b = b;
    u.acc   = op;
    u.dst   = d;
    u.last  = l;
    return u;
  endfunction

  // Each sequence is a short list of products accumulated into one or two destination registers.
  function automatic uop_t uop_f(grp_t g, logic [IDX_W-1:0] i);
    uop_t u;
    u = mk(OPD_ONE, OPD_ONE, ACC_LOAD, DST_NONE, 1'b1);
    case (g)
      G_NORM: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_A, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_A, OPD_B, ACC_SUB, DST_NONE, 1'b0);
          default: u = mk(OPD_B, OPD_B, ACC_ADD, DST_NX, 1'b1);
        endcase
      end
      G_ADD, G_SUB: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_ONE, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_C, OPD_ONE, (g == G_ADD) ? ACC_ADD : ACC_SUB, DST_R0, 1'b0);
          3'd2:    u = mk(OPD_B, OPD_ONE, ACC_LOAD, DST_NONE, 1'b0);
          default: u = mk(OPD_D, OPD_ONE, (g == G_ADD) ? ACC_ADD : ACC_SUB, DST_R1, 1'b1);
        endcase
      end
      G_NEG: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_ONE, ACC_LOADNEG, DST_R0, 1'b0);
          default: u = mk(OPD_B, OPD_ONE, ACC_LOADNEG, DST_R1, 1'b1);
        endcase
      end
      G_MUL: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_C, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_B, OPD_D, ACC_SUB, DST_R0, 1'b0);
          3'd2:    u = mk(OPD_A, OPD_D, ACC_LOAD, DST_NONE, 1'b0);
          3'd3:    u = mk(OPD_B, OPD_C, ACC_ADD, DST_NONE, 1'b0);
          default: u = mk(OPD_B, OPD_D, ACC_SUB, DST_R1, 1'b1);
        endcase
      end
      G_CONJ: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_ONE, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_B, OPD_ONE, ACC_SUB, DST_R0, 1'b0);
          default: u = mk(OPD_B, OPD_ONE, ACC_LOADNEG, DST_R1, 1'b1);
        endcase
      end
      G_PWR: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_P0, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_B, OPD_P1, ACC_SUB, DST_R0, 1'b0);
          3'd2:    u = mk(OPD_A, OPD_P1, ACC_LOAD, DST_NONE, 1'b0);
          3'd3:    u = mk(OPD_B, OPD_P0, ACC_ADD, DST_NONE, 1'b0);
          default: u = mk(OPD_B, OPD_P1, ACC_SUB, DST_R1, 1'b1);
        endcase
      end
      G_NY: begin
        case (i)
          3'd0:    u = mk(OPD_C, OPD_C, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_C, OPD_D, ACC_SUB, DST_NONE, 1'b0);
          default: u = mk(OPD_D, OPD_D, ACC_ADD, DST_NY, 1'b1);
        endcase
      end
      G_PA: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_C, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_A, OPD_D, ACC_SUB, DST_NONE, 1'b0);
          default: u = mk(OPD_B, OPD_D, ACC_ADD, DST_R0, 1'b1);
        endcase
      end
      G_PB: begin
        case (i)
          3'd0:    u = mk(OPD_B, OPD_C, ACC_LOAD, DST_NONE, 1'b0);
          default: u = mk(OPD_A, OPD_D, ACC_SUB, DST_R1, 1'b1);
        endcase
      end
      G_REM: begin
        case (i)
          3'd0:    u = mk(OPD_A, OPD_ONE, ACC_LOAD, DST_NONE, 1'b0);
          3'd1:    u = mk(OPD_P0, OPD_C, ACC_SUB, DST_NONE, 1'b0);
          3'd2:    u = mk(OPD_P1, OPD_D, ACC_ADD, DST_R2, 1'b0);
          3'd3:    u = mk(OPD_B, OPD_ONE, ACC_LOAD, DST_NONE, 1'b0);
          3'd4:    u = mk(OPD_P0, OPD_D, ACC_SUB, DST_NONE, 1'b0);
          3'd5:    u = mk(OPD_P1, OPD_C, ACC_SUB, DST_NONE, 1'b0);
          default: u = mk(OPD_P1, OPD_D, ACC_ADD, DST_R3, 1'b1);
        endcase
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== src/eisenstein_integer_alu.sv =====
// Top level of the Eisenstein integer ALU: sequencer, operand registers and result register.
//
// Usage: one transaction on the input channel (in_valid / in_stall / in_data) carries a
// request: an operation code, two Eisenstein integers x = x_real + x_omega*w and
// y = y_real + y_omega*w, and an exponent. Each request gives exactly one transaction on the
// result channel (out_valid / out_stall / out_data) carrying the result, the division
// remainder, the norm of x and a status code.
// All arithmetic runs on one shared 32x32 multiplier feeding a wide accumulator, stepped by a
// micro-op sequencer, plus a bit-serial divider for the division request. Every request first
// forms the norm of x. Norm then ends; negate, conjugate, add, subtract and multiply run one
// product sequence each; power runs one multiplication per unit of the exponent, stopping on
// overflow; division forms the norm of y, reports a zero-norm divisor without dividing, and
// otherwise rounds the quotient by two 66-step restoring divisions of one bit per cycle, then
// forms the remainder if the quotient fits. One request is in flight at a time: in_stall stays
// high from acceptance until the result has been taken, so requests are handled strictly one
// after another. Reset is synchronous and active low; it returns the block to idle and drops
// out_valid. While the receiver stalls, out_data holds steady and no new request is taken.
`default_nettype none
`include "eisenstein_integer_alu_defines.svh"
module eisenstein_integer_alu #(
  parameter int COMPONENT_BITS = 32,
  parameter int MAX_EXPONENT   = 63
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire eia_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output eia_pkg::out_t      out_data
);

  localparam int AW = eia_pkg::ACC_W;
  localparam int CW = eia_pkg::COMP_W;
  localparam int NW = eia_pkg::NORM_W;
  localparam int EW = eia_pkg::EXP_W;
  localparam int IW = eia_pkg::IDX_W;

  // Signed range that every result component must fall into.
  localparam logic signed [AW-1:0] CMP_MAX = AW'((64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] CMP_MIN = -CMP_MAX - AW'(1);

  function automatic logic fits(logic signed [AW-1:0] v);
    return (v >= CMP_MIN) && (v <= CMP_MAX);
  endfunction

  // Sequencer state.
  eia_pkg::state_t    state_r, state_nxt;
  eia_pkg::grp_t      grp_r, grp_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  eia_pkg::req_type_t op_r, op_nxt;
  logic [EW-1:0]      cnt_r, cnt_nxt;
  eia_pkg::status_t   stat_r, stat_nxt;

  // Operands, running power product (also the rounded quotient for the remainder step).
  logic signed [CW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic signed [CW-1:0] p0_r, p0_nxt, p1_r, p1_nxt;

  // Full-width partial results and norms.
  logic signed [AW-1:0] r0_r, r0_nxt, r1_r, r1_nxt, r2_r, r2_nxt, r3_r, r3_nxt;
  logic [NW-1:0]        nx_r, nx_nxt, ny_r, ny_nxt;

  eia_pkg::out_t out_r, out_nxt;

  // Shared unit connections.
  eia_pkg::uop_t        uop;
  eia_pkg::mac_ctl_t    mac_issue, mac_wb;
  logic signed [CW-1:0] opa, opb;
  logic signed [AW-1:0] mac_acc;
  logic                 mac_busy;
  logic                 div_start, div_done;
  logic signed [AW-1:0] div_num, div_quo;
  logic                 res_ok;

  eia_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (mac_issue),
    .opa   (opa),
    .opb   (opb),
    .acc   (mac_acc),
    .wb    (mac_wb),
    .busy  (mac_busy)
  );

  eia_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (ny_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign uop     = eia_pkg::uop_f(grp_r, idx_r);
  assign div_num = (grp_r == eia_pkg::G_PB) ? r1_r : r0_r;

  // Multiplier operand selection for the current micro-op.
  always_comb begin
    case (uop.sel_a)
      eia_pkg::OPD_A:  opa = a_r;
      eia_pkg::OPD_B:  opa = b_r;
      eia_pkg::OPD_C:  opa = c_r;
      eia_pkg::OPD_D:  opa = d_r;
      eia_pkg::OPD_P0: opa = p0_r;
      eia_pkg::OPD_P1: opa = p1_r;
      default:         opa = CW'(1);
    endcase
    case (uop.sel_b)
      eia_pkg::OPD_A:  opb = a_r;
      eia_pkg::OPD_B:  opb = b_r;
      eia_pkg::OPD_C:  opb = c_r;
      eia_pkg::OPD_D:  opb = d_r;
      eia_pkg::OPD_P0: opb = p0_r;
      eia_pkg::OPD_P1: opb = p1_r;
      default:         opb = CW'(1);
    endcase
  end

  // A result is good when no earlier error was flagged and every component is in range.
  assign res_ok = (stat_r == eia_pkg::ST_OK) && fits(r0_r) && fits(r1_r) &&
                  fits(r2_r) && fits(r3_r);

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    idx_nxt   = idx_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    r3_nxt    = r3_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    out_nxt   = out_r;
    mac_issue = '0;
    div_start = 1'b0;

    // A finished accumulation lands in its destination register.
    if (mac_wb.valid) begin
      case (mac_wb.dst)
        eia_pkg::DST_NX: nx_nxt = mac_acc[NW-1:0];
        eia_pkg::DST_NY: ny_nxt = mac_acc[NW-1:0];
        eia_pkg::DST_R0: r0_nxt = mac_acc;
        eia_pkg::DST_R1: r1_nxt = mac_acc;
        eia_pkg::DST_R2: r2_nxt = mac_acc;
        eia_pkg::DST_R3: r3_nxt = mac_acc;
        default: ;
      endcase
    end

    case (state_r)
      eia_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.req_type;
          a_nxt    = in_data.x_real;
          b_nxt    = in_data.x_omega;
          c_nxt    = in_data.y_real;
          d_nxt    = in_data.y_omega;
          if (int'(in_data.exponent) > MAX_EXPONENT) begin
            cnt_nxt = EW'(MAX_EXPONENT);
          end else begin
            cnt_nxt = in_data.exponent;
          end
          // Power product starts at one; results start at zero, but r0 at one for power.
          p0_nxt    = CW'(1);
          p1_nxt    = '0;
          r0_nxt    = (in_data.req_type == eia_pkg::REQ_POW) ? AW'(1) : '0;
          r1_nxt    = '0;
          r2_nxt    = '0;
          r3_nxt    = '0;
          stat_nxt  = eia_pkg::ST_OK;
          grp_nxt   = eia_pkg::G_NORM;
          idx_nxt   = '0;
          state_nxt = eia_pkg::S_ISSUE;
        end
      end

      eia_pkg::S_ISSUE: begin
        mac_issue.valid = 1'b1;
        mac_issue.acc   = uop.acc;
        mac_issue.dst   = uop.dst;
        if (uop.last) begin
          state_nxt = eia_pkg::S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      eia_pkg::S_DRAIN: begin
        // Decide what follows once the pipe has written its last result back.
        if (!mac_busy) begin
          idx_nxt   = '0;
          state_nxt = eia_pkg::S_ISSUE;
          case (grp_r)
            eia_pkg::G_NORM: begin
              case (op_r)
                eia_pkg::REQ_ADD:  grp_nxt = eia_pkg::G_ADD;
                eia_pkg::REQ_SUB:  grp_nxt = eia_pkg::G_SUB;
                eia_pkg::REQ_NEG:  grp_nxt = eia_pkg::G_NEG;
                eia_pkg::REQ_MUL:  grp_nxt = eia_pkg::G_MUL;
                eia_pkg::REQ_CONJ: grp_nxt = eia_pkg::G_CONJ;
                eia_pkg::REQ_NORM: state_nxt = eia_pkg::S_FIN;
                eia_pkg::REQ_POW: begin
                  if (cnt_r == '0) begin
                    state_nxt = eia_pkg::S_FIN;
                  end else begin
                    grp_nxt = eia_pkg::G_PWR;
                  end
                end
                default: grp_nxt = eia_pkg::G_NY;
              endcase
            end
            eia_pkg::G_PWR: begin
              // An intermediate out of range stops the power loop with an overflow.
              if (fits(r0_r) && fits(r1_r)) begin
                p0_nxt  = r0_r[CW-1:0];
                p1_nxt  = r1_r[CW-1:0];
                cnt_nxt = cnt_r - 1'b1;
                if (cnt_r == EW'(1)) begin
                  state_nxt = eia_pkg::S_FIN;
                end
              end else begin
                stat_nxt  = eia_pkg::ST_OVERFLOW;
                state_nxt = eia_pkg::S_FIN;
              end
            end
            eia_pkg::G_NY: begin
              if (ny_r == '0) begin
                stat_nxt  = eia_pkg::ST_DIV_ZERO;
                state_nxt = eia_pkg::S_FIN;
              end else begin
                grp_nxt = eia_pkg::G_PA;
              end
            end
            eia_pkg::G_PA, eia_pkg::G_PB: begin
              div_start = 1'b1;
              state_nxt = eia_pkg::S_DIV;
            end
            default: state_nxt = eia_pkg::S_FIN;
          endcase
        end
      end

      eia_pkg::S_DIV: begin
        if (div_done) begin
          if (grp_r == eia_pkg::G_PA) begin
            r0_nxt    = div_quo;
            grp_nxt   = eia_pkg::G_PB;
            idx_nxt   = '0;
            state_nxt = eia_pkg::S_ISSUE;
          end else begin
            r1_nxt = div_quo;
            // The remainder is formed from the quotient only when it is in range.
            if (fits(r0_r) && fits(div_quo)) begin
              p0_nxt    = r0_r[CW-1:0];
              p1_nxt    = div_quo[CW-1:0];
              grp_nxt   = eia_pkg::G_REM;
              idx_nxt   = '0;
              state_nxt = eia_pkg::S_ISSUE;
            end else begin
              stat_nxt  = eia_pkg::ST_OVERFLOW;
              state_nxt = eia_pkg::S_FIN;
            end
          end
        end
      end

      eia_pkg::S_FIN: begin
        out_nxt.norm_value = nx_r;
        if (res_ok) begin
          out_nxt.res_real  = r0_r[CW-1:0];
          out_nxt.res_omega = r1_r[CW-1:0];
          out_nxt.rem_real  = r2_r[CW-1:0];
          out_nxt.rem_omega = r3_r[CW-1:0];
          out_nxt.status    = eia_pkg::ST_OK;
        end else begin
          out_nxt.res_real  = '0;
          out_nxt.res_omega = '0;
          out_nxt.rem_real  = '0;
          out_nxt.rem_omega = '0;
          out_nxt.status    = (stat_r == eia_pkg::ST_OK) ? eia_pkg::ST_OVERFLOW : stat_r;
        end
        state_nxt = eia_pkg::S_OUT;
      end

      eia_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = eia_pkg::S_IDLE;
        end
      end

      default: state_nxt = eia_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eia_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    idx_r  <= idx_nxt;
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    stat_r <= stat_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    r2_r   <= r2_nxt;
    r3_r   <= r3_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != eia_pkg::S_IDLE);
  assign out_valid = (state_r == eia_pkg::S_OUT);
  assign out_data  = out_r;

  // An accepted transaction keeps the input side closed on the next cycle.
  `EIA_ASSERT_NEXT(a_accept_closes, clk, rst_n, in_valid && !in_stall, in_stall, "input open after accept")
  // The shared unit has fully drained before a result is shown.
  `EIA_ASSERT_NOW(a_out_mac_idle, clk, rst_n, out_valid, !mac_busy, "result shown while unit busy")
  // Any error status comes with cleared result and remainder components.
  `EIA_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_data.status != eia_pkg::ST_OK), (out_data.res_real == '0) && (out_data.res_omega == '0) && (out_data.rem_real == '0) && (out_data.rem_omega == '0), "error result not cleared")
  // A zero divisor is only ever reported for a division request.
  `EIA_ASSERT_NOW(a_divzero_op, clk, rst_n, out_valid && (out_data.status == eia_pkg::ST_DIV_ZERO), op_r == eia_pkg::REQ_DIV, "zero divisor on non-division")

endmodule
`default_nettype wire

// ===== src/eia_mac.sv =====
// Shared signed 32x32 multiplier with a registered product and a wide accumulator.
`default_nettype none
module eia_mac (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire eia_pkg::mac_ctl_t             issue,
  input  wire logic signed [eia_pkg::COMP_W-1:0] opa,
  input  wire logic signed [eia_pkg::COMP_W-1:0] opb,
  output logic signed [eia_pkg::ACC_W-1:0]   acc,
  output eia_pkg::mac_ctl_t                  wb,
  output logic                               busy
);

  localparam int PW = 2 * eia_pkg::COMP_W;
  localparam int AW = eia_pkg::ACC_W;

  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] prod_ext;
  eia_pkg::mac_ctl_t    ctl1_r, ctl2_r;

  assign prod_nxt = PW'(opa) * PW'(opb);
  assign prod_ext = AW'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl1_r.valid) begin
      case (ctl1_r.acc)
        eia_pkg::ACC_LOAD:    acc_nxt = prod_ext;
        eia_pkg::ACC_LOADNEG: acc_nxt = -prod_ext;
        eia_pkg::ACC_ADD:     acc_nxt = acc_r + prod_ext;
        eia_pkg::ACC_SUB:     acc_nxt = acc_r - prod_ext;
        default:              acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= issue;
      ctl2_r <= ctl1_r;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc  = acc_r;
  assign wb   = ctl2_r;
  assign busy = ctl1_r.valid | ctl2_r.valid;

endmodule
`default_nettype wire

// ===== src/eia_div.sv =====
// Restoring divider that rounds a signed dividend over an unsigned divisor, tie to lower.
`default_nettype none
module eia_div (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire logic signed [eia_pkg::ACC_W-1:0] num,
  input  wire logic [eia_pkg::DEN_W-1:0]      den,
  output logic signed [eia_pkg::ACC_W-1:0]    quo,
  output logic                                done
);

  localparam int AW = eia_pkg::ACC_W;
  localparam int DW = eia_pkg::DEN_W;
  localparam int CW = eia_pkg::DIV_CNT_W;

  eia_pkg::div_state_t st_r, st_nxt;
  logic [AW-1:0] mag_r, mag_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r, mag_r[AW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    st_nxt   = st_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    case (st_r)
      eia_pkg::DV_IDLE: begin
        if (start) begin
          neg_nxt = num[AW-1];
          mag_nxt = num[AW-1] ? AW'(-num) : AW'(num);
          rem_nxt = '0;
          den_nxt = den;
          cnt_nxt = CW'(AW - 1);
          st_nxt  = eia_pkg::DV_RUN;
        end
      end
      eia_pkg::DV_RUN: begin
        // One quotient bit per cycle; dividend bits shift out as quotient bits shift in.
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = diff[DW-1:0];
          mag_nxt = {mag_r[AW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          mag_nxt = {mag_r[AW-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          st_nxt = eia_pkg::DV_SIGN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      eia_pkg::DV_SIGN: begin
        // Floor for a negative dividend: -q - 1 is ~q when a remainder is left.
        if (neg_r) begin
          if (rem_r != '0) begin
            mag_nxt = ~mag_r;
            rem_nxt = den_r - rem_r;
          end else begin
            mag_nxt = -mag_r;
          end
        end
        st_nxt = eia_pkg::DV_ROUND;
      end
      eia_pkg::DV_ROUND: begin
        // Round up only when the remainder is strictly above half the divisor.
        if ({rem_r, 1'b0} > {1'b0, den_r}) begin
          mag_nxt = mag_r + 1'b1;
        end
        done_nxt = 1'b1;
        st_nxt   = eia_pkg::DV_IDLE;
      end
      default: st_nxt = eia_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= eia_pkg::DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign quo  = signed'(mag_r);
  assign done = done_r;

endmodule
`default_nettype wire
